// File: hdl/cacf_pkg.sv
package cacf_pkg;

    localparam int PIX_W = 8;
    localparam int WIN   = 7;

    // one column entering the window, row 0 (oldest) at index 0
    typedef logic [WIN-1:0][PIX_W-1:0] t_column;

    typedef struct packed {
        logic valid;
        logic full;
    } t_tag;

    typedef struct packed {
        logic valid;
        logic detected;
        logic full;
    } t_result;

endpackage

// File: hdl/cacf_train_sum.sv
module cacf_train_sum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  cacf_pkg::t_column i_col,
    input  cacf_pkg::t_tag    i_tag,
    output cacf_pkg::t_result o_res
);
    import cacf_pkg::*;

    localparam int ROW_W   = WIN * PIX_W;
    localparam int ROWSUM_W = $clog2(WIN * 255 + 1);
    localparam int SUM_W   = $clog2(40 * 255 + 1);
    localparam int CTR     = WIN / 2;

    // window: row r, byte c; byte 0 is the newest column
    logic [ROW_W-1:0]    r_win [WIN];
    logic                r_b_valid;
    logic                r_b_full;

    logic [ROWSUM_W-1:0] r_c_rowsum [WIN];
    logic [PIX_W-1:0]    r_c_center;
    logic                r_c_valid;
    logic                r_c_full;

    logic                r_d_valid;
    logic                r_d_det;
    logic                r_d_full;

    logic [ROWSUM_W-1:0] n_rowsum [WIN];
    logic [SUM_W-1:0]    n_total;
    logic [SUM_W-1:0]    n_thresh;

    // window shift, one column per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= i_tag.valid;
        end
        if (i_en) begin
            r_b_full <= i_tag.full;
            if (i_tag.valid) begin
                for (int r = 0; r < WIN; r++) begin
                    r_win[r] <= {r_win[r][ROW_W-PIX_W-1:0], i_col[r]};
                end
            end
        end
    end

    // per-row training sums; the guard block is the 3x3 around the centre
    always_comb begin
        for (int r = 0; r < WIN; r++) begin
            n_rowsum[r] = '0;
            for (int c = 0; c < WIN; c++) begin
                if (r < CTR - 1 || r > CTR + 1 || c < CTR - 1 || c > CTR + 1) begin
                    n_rowsum[r] = n_rowsum[r] + ROWSUM_W'(r_win[r][c*PIX_W +: PIX_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
        if (i_en) begin
            r_c_full   <= r_b_full;
            r_c_center <= r_win[CTR][CTR*PIX_W +: PIX_W];
            for (int r = 0; r < WIN; r++) begin
                r_c_rowsum[r] <= n_rowsum[r];
            end
        end
    end

    // 40*centre > sum, with 40 = 32 + 8
    always_comb begin
        n_total = '0;
        for (int r = 0; r < WIN; r++) begin
            n_total = n_total + SUM_W'(r_c_rowsum[r]);
        end
        n_thresh = SUM_W'({r_c_center, 5'b0}) + SUM_W'({r_c_center, 3'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
        if (i_en) begin
            r_d_full <= r_c_full;
            r_d_det  <= r_c_full && (n_thresh > n_total);
        end
    end

    assign o_res = '{valid: r_d_valid, detected: r_d_det, full: r_d_full};

    a_det_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && r_d_det |-> r_d_full)
        else $error("detection reported on an incomplete window");

    a_b_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_tag.valid |=> r_b_valid)
        else $error("item lost entering the window");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_d_valid) && $stable(r_c_valid) && $stable(r_b_valid))
        else $error("pipeline moved while stalled");

endmodule

// File: hdl/cell_averaging_cfar_7x7_core.sv
// Channel   Dir  Payload                               Handshake
// s_axis    in   tdata: pixel_value, tuser: start_of_frame   s_axis_tvalid/tready
// m_axis    out  tdata: detected, tuser: window_full     m_axis_tvalid/tready
// cfg       in   i_cfg_data: frame_width                 i_cfg_valid/o_cfg_ready
//
// One item per clock while the skid is empty; stages A to D feed the output register.
// The line store is a single-port-write, registered-read memory; a read that hits the
// column written on the same edge (widths of one) is forwarded.
// Reset: counters cleared, frame_width 640, line store left unwritten (no clearing pass).
// Stalls: a two-entry output (register plus skid) lets the input side run until both fill.
module cell_averaging_cfar_7x7_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
    input  logic        s_axis_tuser,   // [0] start_of_frame

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] detected, [7:1] zero
    output logic        m_axis_tuser,   // [0] window_full

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import cacf_pkg::*;

    localparam int FW_W     = 11;
    localparam int LINE_W   = (WIN - 1) * PIX_W;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int CMPW     = (WW > FW_W) ? WW : FW_W;
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [2:0]      ROW_LAST = 3'd6;
    localparam logic [CMPW-1:0] COL_EDGE = CMPW'(WIN - 1);

    logic [FW_W-1:0]   r_frame_width;
    logic [CW-1:0]     r_col;
    logic [2:0]        r_row;

    logic [LINE_W-1:0] r_line [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_q;
    logic [LINE_W-1:0] r_fwd_data;
    logic              r_fwd;
    logic              r_a_valid;
    logic [PIX_W-1:0]  r_a_pix;
    logic [CW-1:0]     r_a_col;
    logic              r_a_full;

    logic              r_out_valid;
    logic              r_out_det;
    logic              r_out_full;
    logic              r_skid_valid;
    logic              r_skid_det;
    logic              r_skid_full;

    logic              en;
    logic              accept;
    logic [CMPW-1:0]   width_eff;
    logic [CW-1:0]     col_pre;
    logic [2:0]        row_pre;
    logic [CW-1:0]     col_cur;
    logic [2:0]        row_cur;
    logic              full_cur;
    logic [CW-1:0]     n_col;
    logic [2:0]        n_row;
    logic [LINE_W-1:0] stored;
    logic [LINE_W-1:0] wr_data;
    t_column           col_bytes;
    t_tag              a_tag;
    t_result           res;
    logic              push;

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FW_RESET;
        end else if (i_cfg_valid) begin
            r_frame_width <= i_cfg_data;
        end
    end

    // column and row position of the incoming pixel
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = CMPW'(1);
        end else if (CMPW'(r_frame_width) > CMPW'(MAX_WIDTH)) begin
            width_eff = CMPW'(MAX_WIDTH);
        end else begin
            width_eff = CMPW'(r_frame_width);
        end

        col_pre = s_axis_tuser ? '0 : r_col;
        row_pre = s_axis_tuser ? '0 : r_row;

        // width lowered below the current column: wrap to the next row
        if (CMPW'(col_pre) >= width_eff) begin
            col_cur = '0;
            row_cur = (row_pre == ROW_LAST) ? ROW_LAST : row_pre + 3'd1;
        end else begin
            col_cur = col_pre;
            row_cur = row_pre;
        end

        full_cur = (row_cur == ROW_LAST) && (CMPW'(col_cur) >= COL_EDGE);

        if (CMPW'(col_cur) + CMPW'(1) >= width_eff) begin
            n_col = '0;
            n_row = (row_cur == ROW_LAST) ? ROW_LAST : row_cur + 3'd1;
        end else begin
            n_col = col_cur + CW'(1);
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store: oldest row in the low byte
    assign stored  = r_fwd ? r_fwd_data : r_rd_q;
    assign wr_data = {r_a_pix, stored[LINE_W-1:PIX_W]};

    always_ff @(posedge i_clk) begin
        if (en && r_a_valid) begin
            r_line[r_a_col] <= wr_data;
        end
        if (accept) begin
            r_rd_q     <= r_line[col_cur];
            r_fwd_data <= wr_data;
            r_fwd      <= r_a_valid && (r_a_col == col_cur);
            r_a_pix    <= s_axis_tdata;
            r_a_col    <= col_cur;
            r_a_full   <= full_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
        end
    end

    always_comb begin
        for (int r = 0; r < WIN - 1; r++) begin
            col_bytes[r] = stored[r*PIX_W +: PIX_W];
        end
        col_bytes[WIN-1] = r_a_pix;
    end

    assign a_tag = '{valid: r_a_valid, full: r_a_full};

    cacf_train_sum u_train_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_col   (col_bytes),
        .i_tag   (a_tag),
        .o_res   (res)
    );

    // output register with skid
    assign push = en && res.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (push) begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
        if (push) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_det  <= res.detected;
                r_out_full <= res.full;
            end else begin
                r_skid_det  <= res.detected;
                r_skid_full <= res.full;
            end
        end else if (m_axis_tready && r_skid_valid) begin
            r_out_det  <= r_skid_det;
            r_out_full <= r_skid_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_det};
    assign m_axis_tuser  = r_out_full;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while the output register is empty");

    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_LAST)
        else $error("row count beyond saturation");

    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full_cur |-> (row_cur == ROW_LAST) && (CMPW'(col_cur) < width_eff))
        else $error("window marked full outside the frame");

    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_a_valid && (r_a_col == col_cur) |=> r_fwd)
        else $error("line store hazard not forwarded");

endmodule

// File: sim/tb_cell_averaging_cfar_7x7_core.sv
module tb_cell_averaging_cfar_7x7_core;

    import cacf_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 10;

    // idle percentages per phase: none, sender, receiver, both
    localparam logic [3:0][7:0] SRC_IDLE_PCT  = {8'd11, 8'd0,  8'd86, 8'd0};
    localparam logic [3:0][7:0] SINK_IDLE_PCT = {8'd11, 8'd86, 8'd0,  8'd0};

    typedef struct packed {
        logic detected;
        logic full;
    } t_verdict;

    typedef struct packed {
        logic             set_width;
        logic [10:0]      width_val;
        logic [PIX_W-1:0] pix;
        logic             sof;
        logic             want_det;
        logic             want_full;
    } t_probe_row;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tuser;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic [10:0]      i_cfg_data    = '0;

    cell_averaging_cfar_7x7_core #(
        .MAX_WIDTH (MAX_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel_value
        .s_axis_tuser  (s_axis_tuser),   // [0] start_of_frame
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] detected, [7:1] zero
        .m_axis_tuser  (m_axis_tuser),   // [0] window_full
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [47:0]  line_mem [MAX_W];
    logic [55:0]  win_rows [WIN];
    int unsigned  col_ptr;
    int unsigned  row_ptr;
    logic [10:0]  width_reg;

    t_verdict      pending_verdicts [$];
    t_verdict      head;
    int unsigned   err_count    = 0;
    int unsigned   pixels_sent  = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   src_idle_pct  = 0;
    int unsigned   sink_idle_pct = 0;
    int unsigned   hold_req = 0;
    int unsigned   hold_ack = 0;

    // every directed row sees an incomplete window, so 0/0 throughout
    t_probe_row probe_rows [24] = '{
        '{1'b0, 11'd0,    8'd0,   1'b1, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd128, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd1,   1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd254, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'h55,  1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'hAA,  1'b1, 1'b0, 1'b0},  // restart mid-row
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd7,   1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd200, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b1, 11'd7,    8'd255, 1'b0, 1'b0, 1'b0},  // column past new width wraps
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b1, 11'd0,    8'd255, 1'b1, 1'b0, 1'b0},  // zero width acts as one
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b1, 11'd2047, 8'd0,   1'b1, 1'b0, 1'b0},  // clamps to max width
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b1, 11'd1024, 8'd255, 1'b1, 1'b0, 1'b0},
        '{1'b1, 11'd6,    8'd0,   1'b0, 1'b0, 1'b0},  // too narrow for a full window
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b0, 11'd0,    8'd17,  1'b0, 1'b0, 1'b0}
    };

    function automatic int unsigned clamp_width(input logic [10:0] w);
        if (w == 0) begin
            return 1;
        end
        return (w > MAX_W) ? MAX_W : int'(w);
    endfunction

    function automatic t_verdict cfar_predict(input logic [PIX_W-1:0] pix, input logic sof);
        int unsigned   w;
        int unsigned   col;
        int unsigned   train_sum;
        int unsigned   centre;
        logic [47:0]   stored;
        t_verdict      v;
        w = clamp_width(width_reg);
        if (sof) begin
            col_ptr = 0;
            row_ptr = 0;
        end
        if (col_ptr >= w) begin
            col_ptr = 0;
            if (row_ptr < 6) row_ptr++;
        end
        col = col_ptr;
        stored = line_mem[col];
        for (int r = 0; r < 6; r++) begin
            win_rows[r] = {win_rows[r][47:0], stored[8*r +: 8]};
        end
        win_rows[6] = {win_rows[6][47:0], pix};
        line_mem[col] = {pix, stored[47:8]};
        // training cells: 7x7 box less the 3x3 guard block
        train_sum = 0;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN; c++) begin
                if (r < 2 || r > 4 || c < 2 || c > 4) train_sum += win_rows[r][8*c +: 8];
            end
        end
        centre = win_rows[3][31:24];
        v.full = (row_ptr >= 6) && (col >= 6);
        v.detected = v.full && (40 * centre > train_sum);
        if (col + 1 >= w) begin
            col_ptr = 0;
            if (row_ptr < 6) row_ptr++;
        end else begin
            col_ptr = col + 1;
        end
        return v;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                              input bit typed, input t_verdict want);
        t_verdict v;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        v = cfar_predict(pix, sof);
        pending_verdicts.push_back(typed ? want : v);
        pixels_sent++;
    endtask

    task automatic await_results();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [10:0] w);
        await_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    // one frame of random content; a wider line always restarts the frame so
    // that no line store column is read before this frame has written it
    task automatic run_frame(input logic [10:0] width_val, input int unsigned rows,
                             input int unsigned style);
        int unsigned      w;
        int unsigned      glitch_at;
        int unsigned      flat_base;
        bit               lead_sof;
        logic [PIX_W-1:0] pix;
        w = clamp_width(width_val);
        lead_sof = (w > clamp_width(width_reg)) || ($urandom_range(9) != 0);
        if (width_val != width_reg) set_width(width_val);
        glitch_at = ($urandom_range(9) == 0) ? $urandom_range(1, w * rows - 1) : 0;
        flat_base = $urandom_range(252);
        for (int unsigned n = 0; n < w * rows; n++) begin
            case (style)
                0: pix = PIX_W'($urandom_range(255));
                1: pix = PIX_W'(($urandom_range(99) < 8) ? $urandom_range(160, 255)
                                                         : $urandom_range(40));
                2: pix = $urandom_range(1) ? 8'd255 : 8'd0;
                default: pix = PIX_W'(flat_base + $urandom_range(3));
            endcase
            send_pixel(pix, (n == 0) ? lead_sof : (n == glitch_at), 1'b0, '0);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                err_count++;
                $display("%0t: unexpected item, tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                head = pending_verdicts.pop_front();
                if (m_axis_tdata !== {7'b0, head.detected}) begin
                    err_count++;
                    $display("%0t: detected expected %h got %h",
                             $time, {7'b0, head.detected}, m_axis_tdata);
                end
                if (m_axis_tuser !== head.full) begin
                    err_count++;
                    $display("%0t: window_full expected %b got %b",
                             $time, head.full, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned start_count;
        int unsigned pick;
        int unsigned rows;
        logic [10:0] new_w;
        foreach (line_mem[k]) line_mem[k] = '0;
        foreach (win_rows[k]) win_rows[k] = '0;
        col_ptr   = 0;
        row_ptr   = 0;
        width_reg = 11'd640;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[k]) begin
            if (probe_rows[k].set_width) set_width(probe_rows[k].width_val);
            send_pixel(probe_rows[k].pix, probe_rows[k].sof, 1'b1,
                       {probe_rows[k].want_det, probe_rows[k].want_full});
        end

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct  = SRC_IDLE_PCT[phase];
            sink_idle_pct = SINK_IDLE_PCT[phase];
            start_count   = pixels_sent;
            // long receiver hold-off with the sender still pushing a full frame
            if (phase == 0) begin
                hold_req++;
                run_frame(11'd16, 7, 0);
            end
            while (pixels_sent - start_count < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    new_w = 11'($urandom_range(7, 24));
                end else if (pick < 85) begin
                    new_w = 11'($urandom_range(25, 48));
                end else begin
                    new_w = 11'($urandom_range(0, 6));
                end
                if (pick >= 85) begin
                    rows = $urandom_range(2, 8);
                end else if ($urandom_range(99) < 12) begin
                    rows = $urandom_range(2, 6);   // cut short before a full window
                end else begin
                    rows = $urandom_range(7, 9);
                end
                run_frame(new_w, rows, $urandom_range(3));
            end
            await_results();
        end

        await_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
